// ===== hdl/pfc_pkg.sv =====
// Shared types and constants for the partitioned FIR convolver.
// Used by every module of the block; depends on nothing.
package pfc_pkg;

  localparam int BLK_LEN    = 64;
  localparam int PARTITIONS = 16;
  localparam int TAPS       = BLK_LEN * PARTITIONS;
  localparam int HIST_DEPTH = TAPS + BLK_LEN;
  localparam int TAP_W      = $clog2(TAPS);
  localparam int HIST_W     = $clog2(HIST_DEPTH);
  localparam int POS_W      = 6;
  localparam int ACC_W      = 42;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] sample_in;
    logic [9:0]        tap_index;
    logic signed [15:0] tap_value;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/pfc_front.sv =====
// Front end: accepts input items and queues them for the back end.
// Depends on pfc_pkg.
module pfc_front import pfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // sample_in, tap_index, tap_value, zero pad
  input  logic        s_tuser,  // kind
  input  logic        busy_clear,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  item_t             in_item;

  always_comb begin
    in_item.kind      = s_tuser;
    in_item.sample_in = s_tdata[15:0];
    in_item.tap_index = s_tdata[25:16];
    in_item.tap_value = s_tdata[41:26];
  end

  assign s_tready = (count != (QPTR_W+1)'(QDEPTH)) && !busy_clear;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count < (QPTR_W+1)'(QDEPTH)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0) else $error("queue underflow");
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    busy_clear |-> !s_tready) else $error("accept during clear");

endmodule

// ===== hdl/pfc_back.sv =====
// Back end: tap and history memories, one multiply-accumulate unit, output register.
// Depends on pfc_pkg.
module pfc_back import pfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  output_shift,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        busy_clear,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  logic signed [15:0] tap_mem  [TAPS];
  logic signed [15:0] hist_mem [HIST_DEPTH];

  state_t state, state_next;

  logic [HIST_W-1:0] clr_addr;
  logic [HIST_W-1:0] head;
  logic [HIST_W-1:0] pos;
  logic [HIST_W-1:0] src;
  logic [TAP_W-1:0]  k;
  logic [POS_W-1:0]  fill;
  logic [POS_W-1:0]  p;
  logic              v1, v2;
  logic signed [15:0] tap_rd, hist_rd;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic signed [15:0] sat_val;
  logic              clip;

  logic pop_item, issue, load_out, hist_we, block_done;
  logic [HIST_W-1:0] hist_waddr;
  logic signed [15:0] hist_wdata;
  logic [15:0]       out_pos16;

  always_comb begin
    pop_item   = (state == ST_IDLE) && q_valid;
    block_done = pop_item && (q_item.kind == KIND_SAMPLE) && (fill == POS_W'(BLK_LEN - 1));
    issue      = (state == ST_MAC);
    load_out   = (state == ST_EMIT) && (!m_tvalid || m_tready);
    busy_clear = (state == ST_CLEAR);
    hist_we    = busy_clear || (pop_item && q_item.kind == KIND_SAMPLE);
    hist_waddr = busy_clear ? clr_addr : head;
    hist_wdata = busy_clear ? 16'sd0 : q_item.sample_in;
    q_pop      = pop_item;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == HIST_W'(HIST_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (block_done) state_next = ST_MAC;
      ST_MAC:   if (k == TAP_W'(TAPS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: if (!v1 && !v2) state_next = ST_EMIT;
      ST_EMIT: begin
        if (load_out) state_next = (p == POS_W'(BLK_LEN - 1)) ? ST_IDLE : ST_MAC;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (pop_item && q_item.kind == KIND_COEF) tap_mem[q_item.tap_index] <= q_item.tap_value;
    tap_rd  <= tap_mem[k];
    hist_rd <= hist_mem[src];
    prod    <= tap_rd * hist_rd;
  end

  always_comb begin
    shifted = acc >>> output_shift;
    clip    = (shifted > ACC_W'(32767)) || (shifted < -ACC_W'(32768));
    if (shifted > ACC_W'(32767))       sat_val = 16'sd32767;
    else if (shifted < -ACC_W'(32768)) sat_val = -16'sd32768;
    else                               sat_val = shifted[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      head     <= '0;
      fill     <= '0;
      p        <= '0;
      k        <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (busy_clear) clr_addr <= clr_addr + 1'b1;
      if (m_tvalid && m_tready && !load_out) m_tvalid <= 1'b0;
      if (pop_item && q_item.kind == KIND_SAMPLE) begin
        head <= (head == HIST_W'(HIST_DEPTH - 1)) ? '0 : head + 1'b1;
        fill <= block_done ? '0 : fill + 1'b1;
      end
      if (block_done) begin
        p   <= '0;
        k   <= '0;
        pos <= (head >= HIST_W'(BLK_LEN - 1)) ? head - HIST_W'(BLK_LEN - 1)
                                              : head + HIST_W'(TAPS + 1);
        src <= (head >= HIST_W'(BLK_LEN - 1)) ? head - HIST_W'(BLK_LEN - 1)
                                              : head + HIST_W'(TAPS + 1);
        acc <= '0;
      end
      if (issue) begin
        k   <= k + 1'b1;
        src <= (src == '0) ? HIST_W'(HIST_DEPTH - 1) : src - 1'b1;
      end
      if (v2) acc <= acc + ACC_W'(prod);
      if (load_out) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {2'b00, p, sat_val};
        m_tlast  <= (p == POS_W'(BLK_LEN - 1));
        m_tuser  <= clip;
        p        <= p + 1'b1;
        k        <= '0;
        acc      <= '0;
        pos      <= (pos == HIST_W'(HIST_DEPTH - 1)) ? '0 : pos + 1'b1;
        src      <= (pos == HIST_W'(HIST_DEPTH - 1)) ? '0 : pos + 1'b1;
      end
    end
  end

  assign out_pos16 = {10'd0, m_tdata[21:16]};

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !v1 && !v2) else $error("pipeline busy in idle");
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1)) else $error("pipeline order broken");
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> out_pos16 == 16'(BLK_LEN - 1)) else $error("last misplaced");

endmodule

// ===== hdl/partitioned_fir_convolver_top.sv =====
// Partitioned FIR convolver: a 1024-tap FIR over blocks of 64 samples.
// After reset the history memory is cleared with no item accepted. Each
// output runs all 1024 taps through the single multiply-accumulate unit,
// drains the pipeline and then loads the output register, which waits
// while the previous output has not been taken.
// Depends on pfc_pkg, pfc_front and pfc_back.
module partitioned_fir_convolver_top import pfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // sample_in, tap_index, tap_value, zero pad
  input  logic        s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // sample_out, out_position, zero pad
  output logic        m_tlast,  // last
  output logic        m_tuser   // clipped
);

  logic [4:0] output_shift;
  logic       q_valid;
  logic       q_pop;
  logic       busy_clear;
  item_t      q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_shift <= 5'd15;
    end else if (cfg_wr_en) begin
      output_shift <= cfg_wr_data;
    end
  end

  pfc_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .busy_clear, .q_valid, .q_item, .q_pop
  );

  pfc_back u_back (
    .clk, .rst, .output_shift, .q_valid, .q_item, .q_pop, .busy_clear,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

endmodule

// ===== tb/pfc_checker.sv =====
// Output checker for the partitioned FIR convolver: it watches the config port and both
// streams, predicts every block run with its own FIR model and compares item by item.
// Depends on pfc_pkg.
module pfc_checker import pfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [5:0]         out_position;
    logic               last;
    logic               clipped;
  } filt_out_t;

  logic signed [15:0] coef_mem [TAPS];
  logic signed [15:0] hist_mem [HIST_DEPTH];
  int                 hist_head;
  int                 fill;
  logic [4:0]         shift_amt;
  filt_out_t          pending_outputs [$];

  assign pending_count = pending_outputs.size();

  task automatic predict_block();
    int          pos;
    int          src;
    longint      acc;
    longint      y;
    filt_out_t   r;
    for (int p = 0; p < BLK_LEN; p++) begin
      pos = (hist_head + HIST_DEPTH - BLK_LEN + p) % HIST_DEPTH;
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
        src = (pos + HIST_DEPTH - k) % HIST_DEPTH;
        acc += longint'(coef_mem[k]) * longint'(hist_mem[src]);
      end
      y = acc >>> shift_amt;
      r.clipped = 1'b0;
      if (y > 32767) begin
        y = 32767;
        r.clipped = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        r.clipped = 1'b1;
      end
      r.sample_out   = y[15:0];
      r.out_position = p[5:0];
      r.last         = (p == BLK_LEN - 1);
      pending_outputs.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    filt_out_t exp_r;
    filt_out_t got_r;
    if (rst) begin
      for (int i = 0; i < TAPS; i++) coef_mem[i] = '0;
      for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
      hist_head = 0;
      fill = 0;
      shift_amt = 5'd15;
      fail_count = 0;
      pending_outputs.delete();
    end else begin
      if (cfg_wr_en) shift_amt = cfg_wr_data;
      if (m_tvalid && m_tready) begin
        got_r = {m_tdata[15:0], m_tdata[21:16], m_tlast, m_tuser};
        if (pending_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected output item: %h", got_r);
        end else begin
          exp_r = pending_outputs.pop_front();
          if (got_r !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"output mismatch: expected out=%0d pos=%0d last=%b clip=%b,",
                        " got out=%0d pos=%0d last=%b clip=%b"},
                       exp_r.sample_out, exp_r.out_position, exp_r.last, exp_r.clipped,
                       got_r.sample_out, got_r.out_position, got_r.last, got_r.clipped);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_COEF) begin
          if (s_tdata[25:16] < TAPS) coef_mem[s_tdata[25:16]] = s_tdata[41:26];
        end else begin
          hist_mem[hist_head] = s_tdata[15:0];
          hist_head = (hist_head + 1) % HIST_DEPTH;
          fill++;
          if (fill == BLK_LEN) begin
            fill = 0;
            predict_block();
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the partitioned FIR convolver testbench: clock, reset, stimulus and verdict.
// Depends on pfc_pkg, partitioned_fir_convolver_top and pfc_checker.
module testbench import pfc_pkg::*;;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  int          fail_count;
  int          pending_count;
  int          cycles;
  int          stall_left;
  bit          quiet;
  int          fill;

  partitioned_fir_convolver_top u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  pfc_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .fail_count(fail_count), .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(logic kind, logic [15:0] smp, logic [9:0] idx, logic [15:0] val);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'b0, val, idx, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == KIND_SAMPLE) fill = (fill + 1) % BLK_LEN;
  endtask

  task automatic send_sample(logic [15:0] smp);
    send_item(KIND_SAMPLE, smp, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_coef(logic [9:0] idx, logic [15:0] val);
    send_item(KIND_COEF, 16'($urandom_range(0, 65535)), idx, val);
  endtask

  task automatic settle_and_config(logic [4:0] shift_val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= shift_val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_sample();
    case ($urandom_range(0, 9))
      0:       send_sample(16'h7FFF);
      1:       send_sample(16'h8000);
      default: send_sample(16'($urandom_range(0, 65535)));
    endcase
  endtask

  initial begin
    logic [4:0] shift_val;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_SAMPLE;
    m_tready = 1'b0;
    cycles = 0;
    stall_left = 0;
    quiet = 1'b0;
    fill = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every tap is loaded before any block can complete.
    for (int i = 0; i < TAPS; i++) send_coef(10'(i), 16'($urandom_range(0, 65535)));

    // Directed block at the reset shift, with extreme taps, samples and a mid-block rewrite.
    send_coef(10'd0, 16'h7FFF);
    send_coef(10'd1023, 16'h8000);
    send_coef(10'd1, 16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_coef(10'd5, 16'h8000);
    send_coef(10'd6, 16'h7FFF);
    while (fill != 0) random_sample();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       shift_val = 5'd0;
        1:       shift_val = 5'd31;
        default: shift_val = 5'($urandom_range(16, 24));
      endcase
      settle_and_config(shift_val);
      if (ph == 4) quiet = 1'b1;
      do begin
        if ($urandom_range(0, 6) == 0)
          send_coef(10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)));
        else random_sample();
      end while (fill != 0);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
